[rtl/core/drsq_pkg.sv]
// ============================================================================
// drsq_pkg: shared types for the disk request sorted queue
// Operation codes and sequencer states.
// ============================================================================
package drsq_pkg;

    typedef enum logic [1:0] {
        OP_REQUEST = 2'd0,
        OP_RELEASE = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_SET_CUR = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD_RD,
        ST_HEAD_LD,
        ST_CMP_RD,
        ST_CMP_WR,
        ST_INS_RD,
        ST_INS_CHK,
        ST_INS_HEAD,
        ST_DONE
    } state_t;

endpackage

[rtl/core/disk_request_sorted_queue.sv]
// ============================================================================
// disk_request_sorted_queue: disk request scheduler with sorted wait queue
// Serves one request at a time; waiting requests sit in ascending track order.
// ============================================================================
// Usage:
//   Command channel: op/pid/track are taken at a clock edge where start is
//   high and busy is low. busy stays high until the result word is out.
//   Result channel: done pulses for one cycle; busy_res, serving_pid,
//   serving_track, released_valid, released_pid, queue_count and overflow
//   are valid in that cycle. The receiver cannot stall, so every result word
//   is taken the cycle it appears.
// Sequencing (N = waiting entries before the command, k = entries moved):
//   request while idle, full-queue drop, request into empty queue,
//   set-current, release with empty queue: done with no RAM scan.
//   request into the queue: walks down from the tail, k entries moving up one
//   place; when all N move, the new entry takes the head slot (ST_INS_HEAD).
//   release / remove: the queue is compacted entry by
//   entry through the single RAM read port.
//   The next command can be accepted the cycle after done.
// Entries live in one RAM (pid and track side by side); the scan walks it
// one entry per read/write state pair because read data comes back registered.
// Reset clears the serving state and empties the queue; RAM contents are
// left as they are since entries at or above the count are never read.
// ============================================================================
module disk_request_sorted_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int PID_BITS    = 8,
    parameter int TRACK_BITS  = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         op,
    input  logic [PID_BITS-1:0]                pid,
    input  logic [TRACK_BITS-1:0]              track,
    output logic                               done,
    output logic                               busy_res,
    output logic [PID_BITS-1:0]                serving_pid,
    output logic [TRACK_BITS-1:0]              serving_track,
    output logic                               released_valid,
    output logic [PID_BITS-1:0]                released_pid,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   queue_count,
    output logic                               overflow
);

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W  = PID_BITS + TRACK_BITS;

    // sequencer state
    drsq_pkg::state_t state_reg, state_next;

    // scheduler state
    logic                  srv_busy_reg, srv_busy_next;
    logic [PID_BITS-1:0]   srv_pid_reg, srv_pid_next;
    logic [TRACK_BITS-1:0] srv_trk_reg, srv_trk_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    // latched command
    logic [PID_BITS-1:0]   cmd_pid_reg, cmd_pid_next;
    logic [TRACK_BITS-1:0] cmd_trk_reg, cmd_trk_next;
    logic                  purge_reg, purge_next;

    // scan indexes: rd walks the queue, wr is the compaction target
    logic [CNT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]      wr_idx_reg, wr_idx_next;

    // result flags
    logic                  rel_valid_reg, rel_valid_next;
    logic [PID_BITS-1:0]   rel_pid_reg, rel_pid_next;
    logic                  ovf_reg, ovf_next;

    // RAM port
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [ENT_W-1:0]      ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [ENT_W-1:0]      ram_rdata;
    logic [PID_BITS-1:0]   rd_pid;
    logic [TRACK_BITS-1:0] rd_trk;

    assign rd_pid = ram_rdata[ENT_W-1:TRACK_BITS];
    assign rd_trk = ram_rdata[TRACK_BITS-1:0];

    drsq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= drsq_pkg::ST_IDLE;
            srv_busy_reg <= 1'b0;
            srv_pid_reg  <= '0;
            srv_trk_reg  <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            srv_busy_reg <= srv_busy_next;
            srv_pid_reg  <= srv_pid_next;
            srv_trk_reg  <= srv_trk_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_pid_reg   <= cmd_pid_next;
        cmd_trk_reg   <= cmd_trk_next;
        purge_reg     <= purge_next;
        rd_idx_reg    <= rd_idx_next;
        wr_idx_reg    <= wr_idx_next;
        rel_valid_reg <= rel_valid_next;
        rel_pid_reg   <= rel_pid_next;
        ovf_reg       <= ovf_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        srv_busy_next  = srv_busy_reg;
        srv_pid_next   = srv_pid_reg;
        srv_trk_next   = srv_trk_reg;
        cnt_next       = cnt_reg;
        cmd_pid_next   = cmd_pid_reg;
        cmd_trk_next   = cmd_trk_reg;
        purge_next     = purge_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        rel_valid_next = rel_valid_reg;
        rel_pid_next   = rel_pid_reg;
        ovf_next       = ovf_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = {cmd_pid_reg, cmd_trk_reg};
        ram_raddr      = rd_idx_reg[ADDR_W-1:0];

        case (state_reg)
            drsq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd_pid_next   = pid;
                    cmd_trk_next   = track;
                    rel_valid_next = 1'b0;
                    rel_pid_next   = '0;
                    ovf_next       = 1'b0;
                    purge_next     = 1'b0;
                    rd_idx_next    = '0;
                    wr_idx_next    = '0;
                    state_next     = drsq_pkg::ST_DONE;
                    case (drsq_pkg::op_t'(op))
                        drsq_pkg::OP_REQUEST:
                        begin
                            if (!srv_busy_reg)
                            begin
                                srv_busy_next = 1'b1;
                                srv_pid_next  = pid;
                                srv_trk_next  = track;
                            end
                            else if (cnt_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                ovf_next = 1'b1;
                            end
                            else if (cnt_reg == '0)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = '0;
                                ram_wdata = {pid, track};
                                cnt_next  = CNT_W'(1);
                            end
                            else
                            begin
                                // walk down from the tail
                                rd_idx_next = cnt_reg - CNT_W'(1);
                                state_next  = drsq_pkg::ST_INS_RD;
                            end
                        end
                        drsq_pkg::OP_RELEASE:
                        begin
                            if (srv_busy_reg)
                            begin
                                rel_valid_next = 1'b1;
                                rel_pid_next   = srv_pid_reg;
                            end
                            if (cnt_reg == '0)
                            begin
                                srv_busy_next = 1'b0;
                            end
                            else
                            begin
                                state_next = drsq_pkg::ST_HEAD_RD;
                            end
                        end
                        drsq_pkg::OP_REMOVE:
                        begin
                            purge_next = 1'b1;
                            if (srv_busy_reg && srv_pid_reg == pid)
                            begin
                                rel_valid_next = 1'b1;
                                rel_pid_next   = srv_pid_reg;
                                if (cnt_reg == '0)
                                begin
                                    srv_busy_next = 1'b0;
                                end
                                else
                                begin
                                    state_next = drsq_pkg::ST_HEAD_RD;
                                end
                            end
                            else if (cnt_reg != '0)
                            begin
                                state_next = drsq_pkg::ST_CMP_RD;
                            end
                        end
                        drsq_pkg::OP_SET_CUR:
                        begin
                            srv_busy_next = 1'b1;
                            srv_pid_next  = pid;
                        end
                        default:
                        begin
                            state_next = drsq_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            drsq_pkg::ST_HEAD_RD:
            begin
                ram_raddr  = '0;
                state_next = drsq_pkg::ST_HEAD_LD;
            end

            drsq_pkg::ST_HEAD_LD:
            begin
                // head enters service; rest shifts down (and is purged on remove)
                srv_busy_next = 1'b1;
                srv_pid_next  = rd_pid;
                srv_trk_next  = rd_trk;
                rd_idx_next   = CNT_W'(1);
                wr_idx_next   = '0;
                state_next    = drsq_pkg::ST_CMP_RD;
            end

            drsq_pkg::ST_CMP_RD:
            begin
                if (rd_idx_reg == cnt_reg)
                begin
                    cnt_next   = wr_idx_reg;
                    state_next = drsq_pkg::ST_DONE;
                end
                else
                begin
                    state_next = drsq_pkg::ST_CMP_WR;
                end
            end

            drsq_pkg::ST_CMP_WR:
            begin
                if (!(purge_reg && rd_pid == cmd_pid_reg))
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = wr_idx_reg[ADDR_W-1:0];
                    ram_wdata   = ram_rdata;
                    wr_idx_next = wr_idx_reg + CNT_W'(1);
                end
                rd_idx_next = rd_idx_reg + CNT_W'(1);
                state_next  = drsq_pkg::ST_CMP_RD;
            end

            drsq_pkg::ST_INS_RD:
            begin
                state_next = drsq_pkg::ST_INS_CHK;
            end

            drsq_pkg::ST_INS_CHK:
            begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(rd_idx_reg + CNT_W'(1));
                if (rd_trk > cmd_trk_reg)
                begin
                    // larger track moves up one place
                    ram_wdata = ram_rdata;
                    if (rd_idx_reg == '0)
                    begin
                        // reaching the bottom: new entry goes to the head slot
                        state_next = drsq_pkg::ST_INS_HEAD;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg - CNT_W'(1);
                        state_next  = drsq_pkg::ST_INS_RD;
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = drsq_pkg::ST_DONE;
                end
            end

            drsq_pkg::ST_INS_HEAD:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                cnt_next   = cnt_reg + CNT_W'(1);
                state_next = drsq_pkg::ST_DONE;
            end

            drsq_pkg::ST_DONE:
            begin
                state_next = drsq_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = drsq_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy           = (state_reg != drsq_pkg::ST_IDLE);
    assign done           = (state_reg == drsq_pkg::ST_DONE);
    assign busy_res       = srv_busy_reg;
    assign serving_pid    = srv_busy_reg ? srv_pid_reg : '0;
    assign serving_track  = srv_trk_reg;
    assign released_valid = rel_valid_reg;
    assign released_pid   = rel_pid_reg;
    assign queue_count    = cnt_reg;
    assign overflow       = ovf_reg;

endmodule

[rtl/core/drsq_ram.sv]
// ============================================================================
// drsq_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ============================================================================
module drsq_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/drsq_checker.sv]
// ============================================================================
// drsq_checker: port-level checks for the disk request sorted queue
// Handshake and queue invariants seen at the ports.
// ============================================================================
module drsq_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             done,
    input logic                             busy_res,
    input logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count,
    input logic                             overflow
);

    // result word only appears while a command is in flight
    a_done_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done outside a command");

    // result word lasts a single cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done longer than one cycle");

    // an accepted command always holds the channel busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted without busy");

    // an idle disk never has waiting requests
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !busy_res) |-> (queue_count == '0))
        else $error("idle disk with waiting requests");

    // a drop only happens on a full queue
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflow) |-> (queue_count == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)))
        else $error("overflow with room in queue");

endmodule

bind disk_request_sorted_queue drsq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_drsq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .busy_res    (busy_res),
    .queue_count (queue_count),
    .overflow    (overflow)
);
